@@ rtl/i2da_pkg.sv @@
// Package for the integer to decimal ASCII converter.
// Holds widths, ASCII codes and the pipeline payload type; no dependencies.
package i2da_pkg;

    localparam int BIN_W           = 64;
    localparam int DIGITS          = 20;
    localparam int BCD_W           = DIGITS * 4;
    localparam int DIGIT_IDX_W     = 5;
    localparam int STEPS_PER_STAGE = 4;
    localparam int N_STAGES        = BIN_W / STEPS_PER_STAGE;

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    typedef struct packed {
        logic             neg;
        logic [BIN_W-1:0] bin;
        logic [BCD_W-1:0] bcd;
    } dabble_t;

endpackage

@@ rtl/i2da_dabble_stage.sv @@
// One register stage of the binary to BCD converter: four shift-and-add-3 steps.
// Depends on i2da_pkg.
module i2da_dabble_stage
    import i2da_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  dabble_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output dabble_t out_data
);

    logic    valid_reg;
    dabble_t data_reg;
    dabble_t data_next;

    always_comb
    begin
        data_next = in_data;
        for (int s = 0; s < STEPS_PER_STAGE; s++)
        begin
            for (int d = 0; d < DIGITS; d++)
            begin
                if (data_next.bcd[d*4 +: 4] >= 4'd5)
                begin
                    data_next.bcd[d*4 +: 4] = data_next.bcd[d*4 +: 4] + 4'd3;
                end
            end
            {data_next.bcd, data_next.bin} = {data_next.bcd[BCD_W-2:0], data_next.bin, 1'b0};
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

@@ rtl/i2da_serializer.sv @@
// Digit count stage and character emitter: one ASCII character per cycle.
// Depends on i2da_pkg.
module i2da_serializer
    import i2da_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_neg,
    input  logic [BCD_W-1:0] in_bcd,
    output logic [7:0]       character,
    output logic             last,
    output logic             strobe
);

    logic                   cnt_valid_reg;
    logic                   cnt_neg_reg;
    logic [BCD_W-1:0]       cnt_bcd_reg;
    logic [DIGIT_IDX_W-1:0] cnt_top_reg;
    logic [DIGIT_IDX_W-1:0] cnt_top_next;

    logic                   act_reg;
    logic                   minus_reg;
    logic [BCD_W-1:0]       bcd_reg;
    logic [DIGIT_IDX_W-1:0] idx_reg;

    logic                   done_now;
    logic                   load;
    logic [3:0]             digit;

    always_comb
    begin
        cnt_top_next = '0;
        for (int d = 1; d < DIGITS; d++)
        begin
            if (in_bcd[d*4 +: 4] != 4'd0)
            begin
                cnt_top_next = DIGIT_IDX_W'(d);
            end
        end
    end

    assign done_now = act_reg && !minus_reg && (idx_reg == '0);
    assign load     = cnt_valid_reg && (!act_reg || done_now);
    assign in_ready = !cnt_valid_reg || load;

    assign digit     = bcd_reg[{idx_reg, 2'b00} +: 4];
    assign strobe    = act_reg;
    assign last      = !minus_reg && (idx_reg == '0);
    assign character = minus_reg ? ASCII_MINUS : (ASCII_ZERO + {4'd0, digit});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_valid_reg <= 1'b0;
            act_reg       <= 1'b0;
            minus_reg     <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                cnt_valid_reg <= in_valid;
            end
            if (load)
            begin
                act_reg   <= 1'b1;
                minus_reg <= cnt_neg_reg;
                idx_reg   <= cnt_top_reg;
            end
            else if (act_reg)
            begin
                if (minus_reg)
                begin
                    minus_reg <= 1'b0;
                end
                else if (idx_reg == '0)
                begin
                    act_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cnt_neg_reg <= in_neg;
            cnt_bcd_reg <= in_bcd;
            cnt_top_reg <= cnt_top_next;
        end
        if (load)
        begin
            bcd_reg <= cnt_bcd_reg;
        end
    end

endmodule

@@ rtl/integer_to_decimal_ascii_core.sv @@
// Top level of the signed 64-bit integer to decimal ASCII converter.
// Depends on i2da_pkg, i2da_dabble_stage and i2da_serializer.
//
// Usage:
//   Command channel: drive value and raise start; the transaction is taken at
//   a rising edge where start is high and busy is low.
//   Result channel: one ASCII character per cycle on character, marked by
//   strobe, most significant first; a negative value begins with '-'. last
//   is high on the final character of a number. The receiver cannot stall.
// Pipeline: a command passes through one input register, 16 conversion stages
//   of four shift-and-add-3 steps each, one digit count register and one
//   emitter register before its first character is strobed.
// Throughput: a number of 1 to 20 characters holds the emitter until its
//   last one; a next number already waiting in the digit count register
//   follows it with no gap. The 18 pipeline registers take a new command
//   every cycle until they fill behind the emitter, then busy rises.
// Reset: rst_n clears every valid bit; in-flight numbers are dropped and no
//   strobe is raised until a new command is taken.
module integer_to_decimal_ascii_core
    import i2da_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [BIN_W-1:0] value,
    output logic [7:0]              character,
    output logic                    last,
    output logic                    strobe
);

    logic    stg_valid [0:N_STAGES];
    logic    stg_ready [0:N_STAGES];
    dabble_t stg_data  [0:N_STAGES];

    logic             in_valid_reg;
    logic             in_neg_reg;
    logic [BIN_W-1:0] in_mag_reg;
    logic [BIN_W-1:0] raw;
    logic [BIN_W-1:0] mag_next;
    logic             accept;

    assign raw      = $unsigned(value);
    assign mag_next = raw[BIN_W-1] ? (~raw + BIN_W'(1)) : raw;
    assign busy     = in_valid_reg && !stg_ready[0];
    assign accept   = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!busy)
        begin
            in_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_neg_reg <= raw[BIN_W-1];
            in_mag_reg <= mag_next;
        end
    end

    assign stg_valid[0]    = in_valid_reg;
    assign stg_data[0].neg = in_neg_reg;
    assign stg_data[0].bin = in_mag_reg;
    assign stg_data[0].bcd = '0;

    for (genvar i = 0; i < N_STAGES; i++)
    begin : g_stage
        i2da_dabble_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[i]),
            .in_ready  (stg_ready[i]),
            .in_data   (stg_data[i]),
            .out_valid (stg_valid[i+1]),
            .out_ready (stg_ready[i+1]),
            .out_data  (stg_data[i+1])
        );
    end

    i2da_serializer u_ser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stg_valid[N_STAGES]),
        .in_ready  (stg_ready[N_STAGES]),
        .in_neg    (stg_data[N_STAGES].neg),
        .in_bcd    (stg_data[N_STAGES].bcd),
        .character (character),
        .last      (last),
        .strobe    (strobe)
    );

endmodule

@@ rtl/i2da_checker.sv @@
// Port-level checker for integer_to_decimal_ascii_core, with its bind.
// Depends on i2da_pkg.
module i2da_checker
    import i2da_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic signed [BIN_W-1:0] value,
    input logic [7:0]              character,
    input logic                    last,
    input logic                    strobe
);

    a_value_known: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> !$isunknown(value))
        else $error("transaction taken with an unknown value");

    a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (character == ASCII_MINUS) ||
                   ((character >= ASCII_ZERO) && (character <= ASCII_ZERO + 8'd9)))
        else $error("character outside minus sign and digits");

    a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> character != ASCII_MINUS)
        else $error("transaction ends on a minus sign");

    a_minus_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (character == ASCII_MINUS) |=> strobe && (character != ASCII_MINUS))
        else $error("minus sign not followed by a digit");

    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe)
        else $error("gap inside one number's text");

endmodule

bind integer_to_decimal_ascii_core i2da_checker u_i2da_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .character (character),
    .last      (last),
    .strobe    (strobe)
);
